// File: design/preemptive_tick_scheduler_core_defines.svh
// Assertion macros used by the scheduler top level.
`ifndef PREEMPTIVE_TICK_SCHEDULER_CORE_DEFINES_SVH
`define PREEMPTIVE_TICK_SCHEDULER_CORE_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define PTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication outside reset.
`define PTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/pts_pkg.sv
// Types and constants of the preemptive tick scheduler.
`timescale 1ns / 1ps
package pts_pkg;

  localparam int unsigned TIME_W  = 16;
  localparam int unsigned BURST_W = 10;
  localparam int unsigned PRIO_W  = 10;
  localparam int unsigned KEY_W   = 10;
  localparam int unsigned SLOT_W  = 6;  // covers up to 64 slots
  localparam int unsigned CNT_W   = 7;  // holds 0..64

  localparam logic [KEY_W-1:0]  KEY_LIMIT = KEY_W'(1000);
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [TIME_W-1:0]  arrive_tick;
    logic [BURST_W-1:0] service_ticks;
    logic [PRIO_W-1:0]  priority_req;
  } item_t;

  typedef struct packed {
    logic              idle;
    logic [3:0]        running_slot;
    logic              finished;
    logic [TIME_W-1:0] finish_tick;
    logic [TIME_W-1:0] turn_ticks;
    logic [TIME_W-1:0] wait_ticks;
    logic              all_done;
  } result_t;

  // Running minimum that walks down the cell chain.
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [KEY_W-1:0]   key;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
  } scan_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               load;
    logic               clear;
    logic [CNT_W-1:0]   count;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               wb_en;
    logic [SLOT_W-1:0]  wb_slot;
    logic [BURST_W-1:0] wb_rem;
    logic               wb_fin;
    logic [TIME_W-1:0]  time_now;
    logic               policy;
  } bcast_t;

endpackage

// File: design/preemptive_tick_scheduler_core.sv
// Top level of the preemptive tick scheduler: controller and chain of task cells.
`timescale 1ns / 1ps
// Preemptive tick scheduler over a table of MAX_TASKS task slots. A command is
// taken when start is high and busy is low. A load or clear beat leaves busy
// low. A tick beat walks a minimum search down the chain of task cells, one
// cell per cycle; after the last cell it updates the winner and forms
// completion/turnaround, and then forms waiting time. A tick after every
// task is done answers with all_done and no search. Each result beat is
// shown on result_o for exactly one cycle with result_valid_o high; the
// receiver cannot stall it, so it must be captured on that edge. A load into
// a full table is dropped. Policy is set through cfg_we_i/cfg_wdata_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. 0 picks the lowest priority value, 1 the least
// remaining time; ties go to the lowest slot and keys of 1000 or more never
// run. Time saturates at 65535.
module preemptive_tick_scheduler_core import pts_pkg::*; #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    result_valid_o,
  output result_t result_o,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i
);

`include "preemptive_tick_scheduler_core_defines.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

  logic [1:0]         state_q, state_d;
  logic               policy_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   fin_cnt_q, fin_cnt_d;
  logic [TIME_W-1:0]  time_q, time_d;
  result_t            res_q, res_d;
  logic [BURST_W-1:0] burst_q, burst_d;
  logic               strobe_q, strobe_d;

  bcast_t ctrl;
  scan_t  chain [MAX_TASKS+1];
  scan_t  tail;

  logic               accept, launch;
  logic [TIME_W-1:0]  time_next;
  logic [BURST_W-1:0] load_burst;
  logic [CNT_W-1:0]   fin_cnt_inc;
  logic               idle_fin;

  assign accept     = start && !busy;
  assign busy       = (state_q != ST_IDLE);
  assign tail       = chain[MAX_TASKS];
  assign time_next  = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
  assign load_burst = (item_i.service_ticks == '0) ? BURST_W'(1) : item_i.service_ticks;
  assign fin_cnt_inc = fin_cnt_q + CNT_W'(1);
  assign launch     = accept && (item_i.mode == MODE_TICK) && (fin_cnt_q < cnt_q);

  // search seed: nothing found yet, key at the limit
  always_comb begin
    chain[0]       = '0;
    chain[0].valid = launch;
    chain[0].key   = KEY_LIMIT;
  end

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    pts_cell #(
      .Slot(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .scan_i(chain[g]),
      .scan_o(chain[g+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    fin_cnt_d = fin_cnt_q;
    time_d    = time_q;
    res_d     = res_q;
    burst_d   = burst_q;
    strobe_d  = 1'b0;

    ctrl          = '0;
    ctrl.count    = cnt_q;
    ctrl.arrival  = item_i.arrive_tick;
    ctrl.burst    = load_burst;
    ctrl.prio     = item_i.priority_req;
    ctrl.wb_slot  = tail.slot;
    ctrl.wb_rem   = tail.remaining - BURST_W'(1);
    ctrl.time_now = time_q;
    ctrl.policy   = policy_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.mode)
            MODE_LOAD: begin
              if (cnt_q < FULL_CNT) begin
                ctrl.load = 1'b1;
                cnt_d     = cnt_q + CNT_W'(1);
              end
            end
            MODE_CLEAR: begin
              ctrl.clear = 1'b1;
              cnt_d      = '0;
              fin_cnt_d  = '0;
              time_d     = '0;
            end
            MODE_TICK: begin
              if (fin_cnt_q >= cnt_q) begin
                // everything done: answer at once, time holds
                res_d          = '0;
                res_d.all_done = 1'b1;
                strobe_d       = 1'b1;
              end else begin
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          time_d  = time_next;
          res_d   = '0;
          burst_d = tail.burst;
          state_d = ST_CALC;
          if (!tail.found) begin
            res_d.idle = 1'b1;
          end else begin
            ctrl.wb_en         = 1'b1;
            ctrl.wb_fin        = (tail.remaining == BURST_W'(1));
            res_d.running_slot = 4'(tail.slot);
            if (ctrl.wb_fin) begin
              fin_cnt_d         = fin_cnt_inc;
              res_d.finished    = 1'b1;
              res_d.finish_tick = time_next;
              res_d.turn_ticks  = (time_next >= tail.arrival) ?
                                  time_next - tail.arrival : '0;
              res_d.all_done    = (fin_cnt_inc >= cnt_q);
            end
          end
        end
      end
      ST_CALC: begin
        if (res_q.finished &&
            (res_q.turn_ticks >= TIME_W'(burst_q))) begin
          res_d.wait_ticks = res_q.turn_ticks - TIME_W'(burst_q);
        end else begin
          res_d.wait_ticks = '0;
        end
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      policy_q  <= 1'b0;
      cnt_q     <= '0;
      fin_cnt_q <= '0;
      time_q    <= '0;
      strobe_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      fin_cnt_q <= fin_cnt_d;
      time_q    <= time_d;
      strobe_q  <= strobe_d;
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    burst_q <= burst_d;
  end

  assign result_valid_o = strobe_q;
  assign result_o       = res_q;
  assign idle_fin       = result_o.idle && result_o.finished;

  `PTS_ASSERT_IMP(a_beat_when_idle, result_valid_o, state_q == ST_IDLE, "beat outside idle")
  `PTS_ASSERT_IMP(a_idle_not_fin, result_valid_o, !idle_fin, "idle and finished together")
  `PTS_ASSERT(a_fin_le_cnt, fin_cnt_q <= cnt_q, "finished count above entry count")
  `PTS_ASSERT_IMP(a_tail_in_scan, tail.valid, state_q == ST_SCAN, "search result outside scan")

endmodule

// File: design/pts_cell.sv
// One task slot of the scheduler chain: holds a task and folds it into the running minimum.
`timescale 1ns / 1ps
module pts_cell import pts_pkg::*; #(
  parameter int unsigned Slot = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  bcast_t ctrl_i,
  input  scan_t  scan_i,
  output scan_t  scan_o
);

  localparam logic [CNT_W-1:0]  SLOT_CNT = CNT_W'(Slot);
  localparam logic [SLOT_W-1:0] SLOT_ID  = SLOT_W'(Slot);

  logic [TIME_W-1:0]  arr_q;
  logic [BURST_W-1:0] burst_q;
  logic [PRIO_W-1:0]  prio_q;
  logic [BURST_W-1:0] rem_q;
  logic               fin_q;
  scan_t              scan_q, scan_d;

  logic             load_hit, wb_hit, occupied, eligible, take;
  logic [KEY_W-1:0] key;

  assign load_hit = ctrl_i.load && (ctrl_i.count == SLOT_CNT);
  assign wb_hit   = ctrl_i.wb_en && (ctrl_i.wb_slot == SLOT_ID);
  assign occupied = SLOT_CNT < ctrl_i.count;
  assign eligible = occupied && !fin_q && (arr_q <= ctrl_i.time_now);
  assign key      = ctrl_i.policy ? rem_q : prio_q;
  assign take     = eligible && (key < scan_i.key);

  always_comb begin
    scan_d = scan_i;
    if (take) begin
      scan_d.found     = 1'b1;
      scan_d.key       = key;
      scan_d.slot      = SLOT_ID;
      scan_d.arrival   = arr_q;
      scan_d.burst     = burst_q;
      scan_d.remaining = rem_q;
    end
  end

  // task payload
  always_ff @(posedge clk_i) begin
    if (load_hit) begin
      arr_q   <= ctrl_i.arrival;
      burst_q <= ctrl_i.burst;
      prio_q  <= ctrl_i.prio;
      rem_q   <= ctrl_i.burst;
    end else if (wb_hit) begin
      rem_q <= ctrl_i.wb_rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else if (ctrl_i.clear || load_hit) begin
      fin_q <= 1'b0;
    end else if (wb_hit) begin
      fin_q <= ctrl_i.wb_fin;
    end
  end

  // hand-off register toward the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q <= '0;
    end else if (scan_i.valid) begin
      scan_q <= scan_d;
    end else begin
      scan_q.valid <= 1'b0;
    end
  end

  assign scan_o = scan_q;

endmodule

// File: tb/sv/tb_preemptive_tick_scheduler_core.sv
// Self-checking testbench for the preemptive tick scheduler core.
`timescale 1ns / 1ps
module tb_preemptive_tick_scheduler_core;
  import pts_pkg::*;

  localparam int unsigned SLOTS       = 16;
  localparam int unsigned SETTLE      = SLOTS + 8;
  localparam int unsigned WATCHDOG    = 1000;       // cycles with no beat, no result and no policy write
  localparam int unsigned ITEMS       = 1750;
  localparam int unsigned PRINT_LIMIT = 50;
  localparam logic [1:0]  MODE_NONE   = 2'd3;       // unused command code

  // What the driver does with the next queued entry.
  typedef enum logic [1:0] {ST_BEAT, ST_POLICY, ST_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e kind;
    item_t      item;
    logic       pol;
  } stim_t;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    start       = 1'b0;
  logic    busy;
  item_t   item_i      = '0;
  logic    result_valid_o;
  result_t result_o;
  logic    cfg_we_i    = 1'b0;
  logic    cfg_wdata_i = 1'b0;

  preemptive_tick_scheduler_core #(
    .MAX_TASKS (SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow: task table, time and policy as the block should hold them
  // ---------------------------------------------------------------------------
  logic [TIME_W-1:0]  tab_arrival [SLOTS];
  logic [BURST_W-1:0] tab_burst   [SLOTS];
  logic [PRIO_W-1:0]  tab_prio    [SLOTS];
  logic [BURST_W-1:0] tab_left    [SLOTS];
  bit                 tab_done    [SLOTS];
  int unsigned        task_cnt;
  int unsigned        done_cnt;
  int unsigned        now_t;
  bit                 policy_q;

  result_t     tick_report_q[$];   // reports owed for ticks already taken
  stim_t       stim_q[$];          // commands not yet driven
  int unsigned err_count;
  int unsigned idle_cycles;
  logic        beat_taken = 1'b0;  // a command beat went in at the last rising edge

  function automatic void wipe_table();
    for (int s = 0; s < SLOTS; s++) begin
      tab_arrival[s] = '0;
      tab_burst[s]   = '0;
      tab_prio[s]    = '0;
      tab_left[s]    = '0;
      tab_done[s]    = 1'b0;
    end
    task_cnt = 0;
    done_cnt = 0;
    now_t    = 0;
  endfunction

  // One scheduling tick: pick the eligible task with the smallest key, charge
  // it one unit and work out its report.
  function automatic result_t run_tick();
    result_t     rep;
    int unsigned key;
    int unsigned best_key;
    int unsigned win;
    int unsigned turn;
    bit          found;
    rep = '0;
    if (done_cnt >= task_cnt) begin
      // nothing left: all done, time frozen
      rep.all_done = 1'b1;
      return rep;
    end
    found    = 1'b0;
    win      = 0;
    best_key = 32'(KEY_LIMIT);  // keys at or above the limit never win
    for (int s = 0; s < task_cnt; s++) begin
      if (!tab_done[s] && tab_arrival[s] <= now_t) begin
        key = policy_q ? 32'(tab_left[s]) : 32'(tab_prio[s]);
        if (key < best_key) begin  // strict: ties stay with the lower slot
          best_key = key;
          win      = s;
          found    = 1'b1;
        end
      end
    end
    if (now_t < TIME_MAX) now_t++;
    if (!found) begin
      rep.idle = 1'b1;
      return rep;
    end
    rep.running_slot = win[3:0];
    if (tab_left[win] > 0) tab_left[win]--;
    if (tab_left[win] == 0) begin
      tab_done[win] = 1'b1;
      done_cnt++;
      turn = (now_t >= 32'(tab_arrival[win])) ? now_t - 32'(tab_arrival[win]) : 0;
      rep.finished    = 1'b1;
      rep.finish_tick = now_t[TIME_W-1:0];
      rep.turn_ticks  = turn[TIME_W-1:0];
      rep.wait_ticks  = (turn >= 32'(tab_burst[win])) ?
                        TIME_W'(turn - 32'(tab_burst[win])) : '0;
    end
    rep.all_done = (done_cnt >= task_cnt);
    return rep;
  endfunction

  function automatic void apply_beat(item_t it);
    case (it.mode)
      MODE_LOAD: begin
        if (task_cnt < SLOTS) begin  // full table drops the load
          tab_arrival[task_cnt] = it.arrive_tick;
          tab_burst[task_cnt]   = (it.service_ticks == '0) ? BURST_W'(1) : it.service_ticks;
          tab_left[task_cnt]    = tab_burst[task_cnt];
          tab_prio[task_cnt]    = it.priority_req;
          tab_done[task_cnt]    = 1'b0;
          task_cnt++;
        end
      end
      MODE_CLEAR: wipe_table();
      MODE_TICK:  tick_report_q.push_back(run_tick());
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check result beats against the oldest owed report, then feed the
  // shadow with whatever command beat or policy write this edge takes.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (tick_report_q.size() == 0) begin
          report_mismatch("result beat with no tick report owed");
        end else begin
          want = tick_report_q.pop_front();
          check_field("idle", TIME_W'(result_o.idle), TIME_W'(want.idle));
          check_field("running_slot", TIME_W'(result_o.running_slot),
                      TIME_W'(want.running_slot));
          check_field("finished", TIME_W'(result_o.finished), TIME_W'(want.finished));
          check_field("finish_tick", result_o.finish_tick, want.finish_tick);
          check_field("turn_ticks",  result_o.turn_ticks,  want.turn_ticks);
          check_field("wait_ticks",  result_o.wait_ticks,  want.wait_ticks);
          check_field("all_done", TIME_W'(result_o.all_done), TIME_W'(want.all_done));
        end
      end
      if (start && !busy) apply_beat(item_i);
      if (cfg_we_i) policy_q = cfg_wdata_i;
    end
    beat_taken <= rst_ni && start && !busy;
  end

  // Watchdog: too long with no command beat, no result beat and no policy write.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG) begin
      $display("timeout: no beat for %0d cycles, %0d reports owed",
               idle_cycles, tick_report_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: works off stim_q at the falling edge. Commands go out in bursts
  // with random gaps; a gap can open at any point of a running tick since
  // start simply drops and comes back later. Drain entries hold off until
  // nothing is owed and the block has settled; policy writes follow them.
  // ---------------------------------------------------------------------------
  int unsigned gap_left   = 0;
  int unsigned burst_left = 8;
  int unsigned settle_cnt = 0;

  always @(negedge clk_i) begin
    logic  go;
    item_t nxt;
    logic  we;
    go  = start;
    nxt = item_i;
    we  = 1'b0;
    if (rst_ni) begin
      if (beat_taken) begin
        go = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          case (stim_q[0].kind)
            ST_BEAT: begin
              go  = 1'b1;
              nxt = stim_q[0].item;
              void'(stim_q.pop_front());
            end
            ST_POLICY: begin
              we = 1'b1;
              cfg_wdata_i <= stim_q[0].pol;
              void'(stim_q.pop_front());
            end
            default: begin  // drain
              if (tick_report_q.size() != 0 || busy) begin
                settle_cnt = 0;
              end else if (settle_cnt < SETTLE) begin
                settle_cnt++;
              end else begin
                settle_cnt = 0;
                void'(stim_q.pop_front());
              end
            end
          endcase
        end
      end
    end
    start    <= go;
    item_i   <= nxt;
    cfg_we_i <= we;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic [1:0] mode, logic [TIME_W-1:0] arr,
                           logic [BURST_W-1:0] bt, logic [PRIO_W-1:0] pr);
    stim_t s;
    s.kind               = ST_BEAT;
    s.item.mode          = mode;
    s.item.arrive_tick   = arr;
    s.item.service_ticks = bt;
    s.item.priority_req  = pr;
    s.pol                = 1'b0;
    stim_q.push_back(s);
  endtask

  // Non-load commands carry random junk in the unused fields.
  task automatic push_cmd(logic [1:0] mode);
    push_beat(mode, TIME_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
  endtask

  task automatic push_drain();
    stim_t s;
    s.kind = ST_DRAIN;
    s.item = '0;
    s.pol  = 1'b0;
    stim_q.push_back(s);
  endtask

  task automatic push_policy(logic p);
    stim_t s;
    push_drain();
    s.kind = ST_POLICY;
    s.item = '0;
    s.pol  = p;
    stim_q.push_back(s);
  endtask

  // Mostly early arrivals, short bursts and a narrow priority range so that
  // ties and preemption happen often; now and then the extremes.
  task automatic push_rand_load();
    logic [TIME_W-1:0]  arr;
    logic [BURST_W-1:0] bt;
    logic [PRIO_W-1:0]  pr;
    case ($urandom_range(0, 19))
      0:       arr = TIME_W'($urandom);
      1:       arr = '1;
      default: arr = TIME_W'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 19))
      0, 1:    bt = '0;
      2:       bt = BURST_W'($urandom_range(0, 1023));
      3, 4:    bt = BURST_W'($urandom_range(7, 40));
      default: bt = BURST_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0:       pr = PRIO_W'($urandom_range(0, 1023));
      1:       pr = PRIO_W'($urandom_range(990, 1023));
      default: pr = PRIO_W'($urandom_range(0, 7));
    endcase
    push_beat(MODE_LOAD, arr, bt, pr);
  endtask

  initial begin
    int unsigned n_beats;
    int unsigned n_load;
    int unsigned n_tick;
    int unsigned phase;
    err_count   = 0;
    idle_cycles = 0;
    policy_q    = 1'b0;
    wipe_table();

    // --- directed: empty table, zero burst, out-of-range keys, unused code
    push_beat(MODE_TICK, '1, '1, '1);       // empty table reports all done
    push_beat(MODE_LOAD, '0, '0, '0);       // zero burst is taken as one
    push_beat(MODE_LOAD, 16'd2, '1, '1);    // key too large under both policies
    push_beat(MODE_LOAD, 16'd1, 10'd2, 10'd999);
    push_beat(MODE_NONE, '1, '1, '1);       // ignored, no report
    repeat (5) push_cmd(MODE_TICK);         // finishes, then idle ticks
    push_policy(1'b1);
    push_cmd(MODE_TICK);                    // remaining 1023 still never runs
    push_cmd(MODE_CLEAR);
    push_cmd(MODE_TICK);                    // cleared table: all done again
    push_beat(MODE_LOAD, '0, 10'd3, '0);
    push_beat(MODE_LOAD, '0, 10'd1, 10'd500);
    push_beat(MODE_LOAD, '0, 10'd1, 10'd7); // ties slot 1, lower slot must win
    repeat (4) push_cmd(MODE_TICK);

    // --- far-future arrival and an unrunnable key: ticks stay idle
    push_policy(1'b0);
    push_cmd(MODE_CLEAR);
    push_beat(MODE_LOAD, '1, 10'd3, 10'd1);
    push_beat(MODE_LOAD, '0, 10'd5, 10'd1000);  // blocks all-done, never runs
    repeat (20) push_cmd(MODE_TICK);

    // --- random phases: clear, fill, then ticks with late loads and noise
    n_beats = 0;
    phase   = 0;
    while (n_beats < ITEMS) begin
      phase++;
      if (phase % 3 == 0) begin
        push_policy(1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 3) == 0) begin
        push_drain();  // sender waits until every report is in
      end
      push_cmd(MODE_CLEAR);
      n_load = $urandom_range(1, 18);
      repeat (n_load) push_rand_load();
      n_tick = $urandom_range(4, 45);
      repeat (n_tick) begin
        case ($urandom_range(0, 59))
          0, 1, 2, 3, 4: begin
            push_rand_load();
            n_beats++;
          end
          5, 6:    push_cmd(MODE_NONE);
          7: begin
            push_cmd(MODE_CLEAR);  // broken sequence: wipe mid-run
            n_beats++;
          end
          default: ;
        endcase
        push_cmd(MODE_TICK);
      end
      n_beats += 1 + n_load + n_tick;
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || start) @(posedge clk_i);
    while (tick_report_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);

    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
